>>> rtl/core/gesr_pkg.sv
// Shared types and constants for the graph edge store reachability core.
// Holds request codes, result status codes and the queue entry passed from
// the front end to the back end. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gesr_pkg;

    // Width of every vertex field on the ports.
    localparam int FIELD_W  = 6;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 3;

    // Depth of the queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Request type codes.
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STS_END_MARKER   = 3'd1;
    localparam logic [STATUS_W-1:0] STS_SAME_VERTEX  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_OUT_OF_RANGE = 3'd3;
    localparam logic [STATUS_W-1:0] STS_DUPLICATE    = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NOT_IN_GRAPH = 3'd5;

    // Work left for the back end once the front end has classified a request.
    typedef enum logic [1:0] {
        OP_RESULT,
        OP_CLEAR,
        OP_ADD,
        OP_QUERY
    } op_t;

    // Vertex indices are zero based (vertex number minus one).
    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
        logic                start_ok;
        logic [FIELD_W-1:0]  idx_a;
        logic [FIELD_W-1:0]  idx_b;
    } queue_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/gesr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gesr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/gesr_fifo.sv
// Short queue of classified requests between the front and back end.
// Depends on gesr_pkg for the entry type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module gesr_fifo import gesr_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire queue_entry_t push_data,
    output logic        full,
    input  wire logic   pop,
    output queue_entry_t pop_data,
    output logic        empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    queue_entry_t    entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gesr_front.sv
// Front end: accepts requests and settles every check that needs only the
// vertex count, leaving graph work to the back end. Depends on gesr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gesr_front import gesr_pkg::*; (
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [TYPE_W-1:0]  s_req_type,
    input  wire logic [FIELD_W-1:0] s_vertex_a,
    input  wire logic [FIELD_W-1:0] s_vertex_b,
    input  wire logic [FIELD_W:0]   live_count,
    input  wire logic               queue_full,
    output logic                    push,
    output queue_entry_t            push_data
);

    logic a_ok;
    logic b_ok;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // A vertex is usable when it lies in 1..live_count.
    assign a_ok = (s_vertex_a != '0) && ({1'b0, s_vertex_a} <= live_count);
    assign b_ok = (s_vertex_b != '0) && ({1'b0, s_vertex_b} <= live_count);

    always_comb begin
        push_data          = '0;
        push_data.op       = OP_RESULT;
        push_data.status   = STS_OK;
        push_data.start_ok = a_ok;
        push_data.idx_a    = s_vertex_a - 1'b1;
        push_data.idx_b    = s_vertex_b - 1'b1;
        case (s_req_type)
            REQ_CLEAR: begin
                push_data.op = OP_CLEAR;
            end
            REQ_ADD: begin
                if (s_vertex_a == '0 && s_vertex_b == '0) begin
                    push_data.status = STS_END_MARKER;
                end else if (s_vertex_a == s_vertex_b) begin
                    push_data.status = STS_SAME_VERTEX;
                end else if (!a_ok || !b_ok) begin
                    push_data.status = STS_OUT_OF_RANGE;
                end else begin
                    push_data.op = OP_ADD;
                end
            end
            REQ_QUERY: begin
                if (!b_ok) begin
                    push_data.status = STS_NOT_IN_GRAPH;
                end else begin
                    push_data.op = OP_QUERY;
                end
            end
            default: begin
                push_data.op = OP_RESULT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/gesr_back.sv
// Back end: carries out clears, edge inserts and reachability walks on the
// adjacency rows and holds the result register. Depends on gesr_pkg, gesr_ram.
`timescale 1ns / 1ps
`default_nettype none

module gesr_back import gesr_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [FIELD_W:0]     live_count,
    input  wire logic                 queue_empty,
    input  wire queue_entry_t         head,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic                      m_reachable
);

    localparam int VIW = $clog2(MAX_VERTICES);
    localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD_A,
        ST_ADD_WR_A,
        ST_ADD_WR_B,
        ST_QUERY,
        ST_DONE
    } state_t;

    state_t                  state_reg,     state_next;
    logic [VIW-1:0]          ia_reg,        ia_next;
    logic [VIW-1:0]          ib_reg,        ib_next;
    logic [VIW-1:0]          rd_addr_reg,   rd_addr_next;
    logic [MAX_VERTICES-1:0] visited_reg,   visited_next;
    logic [MAX_VERTICES-1:0] expanded_reg,  expanded_next;
    logic [MAX_VERTICES-1:0] row_vld_reg,   row_vld_next;
    logic                    inflight_reg,  inflight_next;
    logic [STATUS_W-1:0]     status_reg,    status_next;
    logic                    reach_reg,     reach_next;
    logic                    m_valid_reg,   m_valid_next;
    logic [STATUS_W-1:0]     m_status_reg,  m_status_next;
    logic                    m_reach_reg,   m_reach_next;

    logic                    ram_we;
    logic [VIW-1:0]          ram_waddr;
    logic [MAX_VERTICES-1:0] ram_wdata;
    logic [VIW-1:0]          ram_raddr;
    logic [MAX_VERTICES-1:0] ram_rdata;

    logic [MAX_VERTICES-1:0] rd_row;
    logic [MAX_VERTICES-1:0] live_mask;
    logic [MAX_VERTICES-1:0] frontier;
    logic [MAX_VERTICES-1:0] pick_oh;
    logic [VIW-1:0]          pick_idx;
    logic                    out_free;

    gesr_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A row never written since reset or the last clear reads as empty.
    assign rd_row   = row_vld_reg[rd_addr_reg] ? ram_rdata : '0;
    assign frontier = visited_reg & ~expanded_reg;
    assign pick_oh  = frontier & (~frontier + ONE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        live_mask = '0;
        pick_idx  = '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            live_mask[i] = ((FIELD_W + 1)'(i) < live_count);
            if (pick_oh[i]) begin
                pick_idx = pick_idx | VIW'(i);
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        rd_addr_next  = rd_addr_reg;
        visited_next  = visited_reg;
        expanded_next = expanded_reg;
        row_vld_next  = row_vld_reg;
        inflight_next = inflight_reg;
        status_next   = status_reg;
        reach_next    = reach_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_reach_next  = m_reach_reg;
        pop           = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ia_reg;
        ram_wdata     = '0;
        ram_raddr     = ia_reg;

        case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    case (head.op)
                        OP_RESULT, OP_CLEAR: begin
                            if (out_free) begin
                                pop           = 1'b1;
                                m_valid_next  = 1'b1;
                                m_status_next = head.status;
                                m_reach_next  = 1'b0;
                                if (head.op == OP_CLEAR) begin
                                    row_vld_next = '0;
                                end
                            end
                        end
                        OP_ADD: begin
                            pop        = 1'b1;
                            ia_next    = head.idx_a[VIW-1:0];
                            ib_next    = head.idx_b[VIW-1:0];
                            state_next = ST_ADD_RD_A;
                        end
                        OP_QUERY: begin
                            pop           = 1'b1;
                            ib_next       = head.idx_b[VIW-1:0];
                            visited_next  = head.start_ok ? (ONE << head.idx_a[VIW-1:0]) : '0;
                            expanded_next = '0;
                            inflight_next = 1'b0;
                            state_next    = ST_QUERY;
                        end
                        default: begin
                            pop = 1'b0;
                        end
                    endcase
                end
            end
            ST_ADD_RD_A: begin
                ram_raddr    = ia_reg;
                rd_addr_next = ia_reg;
                state_next   = ST_ADD_WR_A;
            end
            ST_ADD_WR_A: begin
                reach_next = 1'b0;
                if (rd_row[ib_reg]) begin
                    status_next = STS_DUPLICATE;
                    state_next  = ST_DONE;
                end else begin
                    ram_we               = 1'b1;
                    ram_waddr            = ia_reg;
                    ram_wdata            = rd_row | (ONE << ib_reg);
                    row_vld_next[ia_reg] = 1'b1;
                    ram_raddr            = ib_reg;
                    rd_addr_next         = ib_reg;
                    state_next           = ST_ADD_WR_B;
                end
            end
            ST_ADD_WR_B: begin
                ram_we               = 1'b1;
                ram_waddr            = ib_reg;
                ram_wdata            = rd_row | (ONE << ia_reg);
                row_vld_next[ib_reg] = 1'b1;
                status_next          = STS_OK;
                state_next           = ST_DONE;
            end
            ST_QUERY: begin
                // Merge the row that arrives this cycle and issue the next read.
                if (inflight_reg) begin
                    visited_next = visited_reg | (rd_row & live_mask);
                end
                if (frontier != '0) begin
                    ram_raddr     = pick_idx;
                    rd_addr_next  = pick_idx;
                    expanded_next = expanded_reg | pick_oh;
                    inflight_next = 1'b1;
                end else begin
                    inflight_next = 1'b0;
                    if (!inflight_reg) begin
                        reach_next  = visited_reg[ib_reg];
                        status_next = STS_OK;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_reach_next  = reach_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_vld_reg  <= '0;
            inflight_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_vld_reg  <= row_vld_next;
            inflight_reg <= inflight_next;
            m_valid_reg  <= m_valid_next;
        end
        ia_reg       <= ia_next;
        ib_reg       <= ib_next;
        rd_addr_reg  <= rd_addr_next;
        visited_reg  <= visited_next;
        expanded_reg <= expanded_next;
        status_reg   <= status_next;
        reach_reg    <= reach_next;
        m_status_reg <= m_status_next;
        m_reach_reg  <= m_reach_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_reachable = m_reach_reg;

endmodule

`default_nettype wire

>>> rtl/core/graph_edge_store_reachability_core.sv
// Top level of the graph edge store reachability core: vertex count register,
// front end, request queue and back end. Depends on gesr_pkg, gesr_front,
// gesr_fifo and gesr_back (which holds the adjacency RAM).
//
// Usage: requests enter on the s_ channel (valid/ready) and each one gives
// exactly one result transfer on the m_ channel, in request order. A request
// is a clear of the graph, an edge insert, or a path query between two
// vertices numbered 1..vertex_count. The vertex count register is written
// through cfg_wr_en/cfg_wr_data and resets to 2; the user must write it only
// while the core is idle, which the core itself does not enforce. The front
// end classifies each request in the cycle of its transfer and places it in
// a two-entry queue, so s_ready stays high while the back end works unless
// the queue fills. The back end answers a clear, an unused type or a request
// rejected by the range checks straight from the queue; an edge insert reads
// and writes the row of each end, stopping after the first read when the edge
// is already stored, and a query reads one row per vertex reached. The query
// time is set by the single read port of the adjacency RAM, which returns a
// row in the cycle after its address; when the frontier runs dry the walk
// waits for the row in flight. Reset empties the queue, the graph and the
// result register at once; no clearing pass is needed. When the receiver
// stalls, the result stays in the output register and the back end holds its
// next result until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module graph_edge_store_reachability_core import gesr_pkg::*; #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [FIELD_W-1:0]  cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [TYPE_W-1:0]   s_req_type,
    input  wire logic [FIELD_W-1:0]  s_vertex_a,
    input  wire logic [FIELD_W-1:0]  s_vertex_b,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic                     m_reachable
);

    localparam logic [FIELD_W:0] MAX_CNT = (FIELD_W + 1)'(MAX_VERTICES);

    logic [FIELD_W-1:0] vcount_reg;
    logic [FIELD_W:0]   live_count;
    logic               queue_full;
    logic               queue_empty;
    logic               push;
    logic               pop;
    queue_entry_t       push_data;
    queue_entry_t       head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= FIELD_W'(2);
        end else if (cfg_wr_en) begin
            vcount_reg <= cfg_wr_data;
        end
    end

    // A count above capacity acts as the capacity.
    assign live_count = ({1'b0, vcount_reg} > MAX_CNT) ? MAX_CNT : {1'b0, vcount_reg};

    gesr_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_vertex_a (s_vertex_a),
        .s_vertex_b (s_vertex_b),
        .live_count (live_count),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    gesr_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (queue_empty)
    );

    gesr_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .live_count  (live_count),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_reachable (m_reachable)
    );

    // Only a successful query can report a reached target.
    a_reach_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reachable |-> m_status == STS_OK)
        else $error("reachable set on a result whose status is not ok");

    // The queue can only fill through a transfer on the input channel.
    a_ready_falls_on_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && s_ready))
        else $error("s_ready dropped without an input transfer");

    // The back end never takes an entry from an empty queue.
    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !queue_empty)
        else $error("back end popped an empty queue");

    // No result is offered in the cycle after reset.
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> test/graph_edge_store_reachability_core_test.sv
// Self-checking testbench for graph_edge_store_reachability_core: edge inserts,
// clears and path queries under random idling, checked against an internal model.
// Depends on gesr_pkg and the core RTL.
`timescale 1ns / 1ps

module graph_edge_store_reachability_core_test;
    import gesr_pkg::*;

    localparam int GRAPH_SIZE = 32;

    // The request channel has two bits, so one code is never assigned a meaning.
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    // Cycles of quiet allowed after the last result before a register write and at the end.
    localparam int SETTLE_CYCLES = 2 * GRAPH_SIZE + 8;

    // The slowest correct gap between transfers is one full query plus a
    // receiver stall plus a register write pause, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                reachable;
    } reply_t;

    // Scoreboard: keeps its own copy of the adjacency matrix and the vertex
    // count, predicts the reply to each accepted request, and matches replies
    // in order against the queue of predictions.
    class reachability_board;
        logic [GRAPH_SIZE-1:0] adjacency [GRAPH_SIZE];
        logic [FIELD_W-1:0]    vertex_count;
        reply_t                expected_replies [$];
        int                    failures;
        int                    replies_seen;

        function new();
            foreach (adjacency[v]) adjacency[v] = '0;
            vertex_count = 6'd2;
            failures = 0;
            replies_seen = 0;
        endfunction

        function bit in_range(logic [FIELD_W-1:0] vertex, int live);
            return vertex >= 1 && vertex <= live;
        endfunction

        function reply_t predict_reply(logic [TYPE_W-1:0] kind, logic [FIELD_W-1:0] a,
                                       logic [FIELD_W-1:0] b);
            reply_t                reply;
            int                    live;
            logic [GRAPH_SIZE-1:0] live_mask;
            logic [GRAPH_SIZE-1:0] reached;
            logic [GRAPH_SIZE-1:0] grown;
            reply = '0;
            live = (vertex_count > GRAPH_SIZE) ? GRAPH_SIZE : int'(vertex_count);
            live_mask = (live >= GRAPH_SIZE) ? '1 : GRAPH_SIZE'((64'd1 << live) - 64'd1);
            case (kind)
                REQ_CLEAR: begin
                    foreach (adjacency[v]) adjacency[v] = '0;
                end
                REQ_ADD: begin
                    if (a == 0 && b == 0) begin
                        reply.status = STS_END_MARKER;
                    end else if (a == b) begin
                        reply.status = STS_SAME_VERTEX;
                    end else if (!in_range(a, live) || !in_range(b, live)) begin
                        reply.status = STS_OUT_OF_RANGE;
                    end else if (adjacency[a - 1][b - 1]) begin
                        reply.status = STS_DUPLICATE;
                    end else begin
                        adjacency[a - 1][b - 1] = 1'b1;
                        adjacency[b - 1][a - 1] = 1'b1;
                    end
                end
                REQ_QUERY: begin
                    if (!in_range(b, live)) begin
                        reply.status = STS_NOT_IN_GRAPH;
                    end else begin
                        // Flood out from the start until the reached set stops
                        // growing; vertices above the count are never entered.
                        reached = in_range(a, live) ? (GRAPH_SIZE'(1) << (a - 1)) : '0;
                        forever begin
                            grown = reached;
                            for (int v = 0; v < live; v++) begin
                                if (reached[v]) grown |= adjacency[v];
                            end
                            grown &= live_mask;
                            if (grown == reached) break;
                            reached = grown;
                        end
                        reply.reachable = reached[b - 1];
                    end
                end
                default: begin
                end
            endcase
            return reply;
        endfunction

        function void note_request(logic [TYPE_W-1:0] kind, logic [FIELD_W-1:0] a,
                                   logic [FIELD_W-1:0] b);
            expected_replies.push_back(predict_reply(kind, a, b));
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic reachable);
            reply_t wanted;
            replies_seen++;
            if (expected_replies.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display({"result %0d arrived with no request outstanding: ",
                              "status %0d reachable %0d"},
                             replies_seen, status, reachable);
                return;
            end
            wanted = expected_replies.pop_front();
            if (status !== wanted.status || reachable !== wanted.reachable) begin
                failures++;
                if (failures <= 10)
                    $display({"result %0d mismatch: expected status %0d reachable %0d, ",
                              "got status %0d reachable %0d"},
                             replies_seen, wanted.status, wanted.reachable,
                             status, reachable);
            end
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void flag_leftovers();
            if (expected_replies.size() != 0) begin
                failures++;
                $display("%0d results never arrived", expected_replies.size());
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [FIELD_W-1:0]  cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [TYPE_W-1:0]   s_req_type = REQ_CLEAR;
    logic [FIELD_W-1:0]  s_vertex_a = '0;
    logic [FIELD_W-1:0]  s_vertex_b = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    logic [STATUS_W-1:0] m_status;
    logic                m_reachable;

    reachability_board board;
    bit                steady = 1'b0;
    int                ready_left = 0;
    int                quiet_cycles = 0;

    always #5 aclk = ~aclk;

    graph_edge_store_reachability_core #(
        .MAX_VERTICES(GRAPH_SIZE)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_vertex_a (s_vertex_a),
        .s_vertex_b (s_vertex_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_reachable(m_reachable)
    );

    // The receiver picks ready or stall at random, ready two times in three, holds
    // each choice for a random stretch, and stays ready once the final phase begins.
    always @(negedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else if (ready_left > 1) begin
            ready_left = ready_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 2) != 0);
            ready_left = $urandom_range(1, 10);
        end
    end

    // Both channels are sampled at the rising edge. A request is noted before
    // any reply is checked, although a reply can never share the edge of its
    // own request transfer. The watchdog counts edges with no transfer at all.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_request(s_req_type, s_vertex_a, s_vertex_b);
            if (m_valid && m_ready) board.check_result(m_status, m_reachable);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL graph_edge_store_reachability_core");
                $finish;
            end
        end
    end

    // Presents one request at a falling edge and holds it until the transfer.
    // Valid is left high; the caller lowers it only when a gap follows, so a
    // back-to-back request never lowers and raises valid in one time step.
    task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [FIELD_W-1:0] a,
                                input logic [FIELD_W-1:0] b);
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_vertex_a <= a;
        s_vertex_b <= b;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        @(negedge aclk);
    endtask

    task automatic hold_off(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Stops sending and waits for every outstanding reply.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    // The count register is only written with the core idle: all replies in,
    // then enough quiet cycles for the back end to have finished its work.
    task automatic write_vertex_count(input logic [FIELD_W-1:0] count);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.vertex_count = count;
    endtask

    function automatic logic [FIELD_W-1:0] pick_vertex(input int live);
        if (live == 0) return FIELD_W'($urandom_range(0, 63));
        return FIELD_W'($urandom_range(1, live));
    endfunction

    // Mostly well-formed inserts and queries on live vertices so that the
    // graph grows and the flood goes deep, with occasional clears to start
    // over, and a share of malformed requests with full-width fields.
    task automatic send_random(input int live, input bit no_gaps);
        int                 pick;
        logic [TYPE_W-1:0]  kind;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        if (!no_gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
        pick = $urandom_range(0, 99);
        a = pick_vertex(live);
        b = pick_vertex(live);
        if (pick < 45) begin
            kind = REQ_ADD;
        end else if (pick < 80) begin
            kind = REQ_QUERY;
        end else if (pick < 83) begin
            kind = REQ_CLEAR;
        end else begin
            kind = TYPE_W'($urandom_range(0, 3));
            a = FIELD_W'($urandom_range(0, 63));
            b = FIELD_W'($urandom_range(0, 63));
            case ($urandom_range(0, 3))
                0: b = a;
                1: begin
                    a = '0;
                    b = '0;
                end
                default: begin
                end
            endcase
        end
        send_request(kind, a, b);
    endtask

    initial begin
        logic [FIELD_W-1:0] phase_counts [10];
        int live;
        int items;

        board = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. The count starts at its reset value of two, so the
        // first inserts also confirm that value.
        send_request(REQ_ADD, 6'd1, 6'd2);
        send_request(REQ_ADD, 6'd1, 6'd3);
        send_request(REQ_QUERY, 6'd2, 6'd1);
        send_request(REQ_ADD, 6'd0, 6'd0);

        write_vertex_count(6'd5);
        send_request(REQ_ADD, 6'd4, 6'd4);
        send_request(REQ_ADD, 6'd0, 6'd3);
        send_request(REQ_ADD, 6'd2, 6'd1);
        send_request(REQ_ADD, 6'd2, 6'd3);
        send_request(REQ_QUERY, 6'd1, 6'd3);
        send_request(REQ_QUERY, 6'd1, 6'd4);
        send_request(REQ_QUERY, 6'd4, 6'd4);
        send_request(REQ_QUERY, 6'd1, 6'd6);
        send_request(REQ_QUERY, 6'd0, 6'd2);
        send_request(REQ_QUERY, 6'd63, 6'd1);
        send_request(REQ_ADD, 6'd63, 6'd63);
        send_request(REQ_ADD, 6'd1, 6'd63);
        send_request(REQ_UNUSED, 6'd63, 6'd63);
        send_request(REQ_CLEAR, 6'd0, 6'd0);
        send_request(REQ_QUERY, 6'd1, 6'd3);
        send_request(REQ_ADD, 6'd1, 6'd5);
        send_request(REQ_ADD, 6'd5, 6'd3);
        send_request(REQ_QUERY, 6'd1, 6'd3);

        // Lowering the count leaves the path through vertex five stored but
        // out of reach, so one and three are no longer joined.
        write_vertex_count(6'd3);
        send_request(REQ_QUERY, 6'd1, 6'd3);
        send_request(REQ_QUERY, 6'd1, 6'd5);
        send_request(REQ_ADD, 6'd1, 6'd5);

        // Random phases, each at its own count: the full size, the smallest
        // useful count, values past capacity, zero and one, and random sizes.
        // The last phase runs without gaps on either side.
        phase_counts = '{6'd32, 6'd2, 6'd63, 6'd0, 6'd1, 6'd0, 6'd0, 6'd0, 6'd0, 6'd32};
        phase_counts[5] = FIELD_W'($urandom_range(3, 10));
        phase_counts[6] = FIELD_W'($urandom_range(11, 31));
        phase_counts[7] = FIELD_W'($urandom_range(33, 62));
        phase_counts[8] = FIELD_W'($urandom_range(3, 31));
        foreach (phase_counts[p]) begin
            write_vertex_count(phase_counts[p]);
            if (p == 9) steady = 1'b1;
            live = (phase_counts[p] > GRAPH_SIZE) ? GRAPH_SIZE : int'(phase_counts[p]);
            items = (live < 2) ? 40 : 220;
            repeat (items) send_random(live, steady);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        board.flag_leftovers();
        if (board.failures == 0) begin
            $display("PASS graph_edge_store_reachability_core");
        end else begin
            $display("FAIL graph_edge_store_reachability_core");
        end
        $finish;
    end

endmodule
